// ===== design/mqrf_pkg.sv =====
// shared types, codes and constants of the multi-queue record fifo
package mqrf_pkg;

    localparam int NUM_QUEUES_DEF = 16;
    localparam int SLOTS_DEF      = 32;
    localparam int SLOT_BYTES_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int QSEL_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 6;
    localparam int PCT_W    = 7;

    localparam int PCT_SCALE = 100;
    // bits that bound used * 100 for any legal slot count
    localparam int PCT_X_W   = 17;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOOLONG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [QSEL_W-1:0] queue_sel;
        logic [BYTE_W-1:0] wr_byte;
        logic              wr_last;
        logic [LEN_W-1:0]  max_len;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rd_ok;
        logic                rd_last;
        logic [LEN_W-1:0]    rec_len;
        logic [FREE_W-1:0]   free_slots;
        logic [PCT_W-1:0]    used_percent;
        logic                data_avail;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_cmd;

endpackage

// ===== design/mqrf_store.sv =====
// record byte store, one write and one registered read per cycle
module mqrf_store #(
    parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
    parameter int SLOTS      = mqrf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = mqrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                          i_clk,
    input  mqrf_pkg::t_store_cmd          i_cmd,
    input  logic [$clog2(NUM_QUEUES*SLOTS*SLOT_BYTES)-1:0] i_waddr,
    input  logic [mqrf_pkg::BYTE_W-1:0]   i_wdata,
    input  logic [$clog2(NUM_QUEUES*SLOTS*SLOT_BYTES)-1:0] i_raddr,
    output logic [mqrf_pkg::BYTE_W-1:0]   o_rd_byte
);

    localparam int DEPTH = NUM_QUEUES * SLOTS * SLOT_BYTES;

    logic [mqrf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [mqrf_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rd_byte = r_rdata;

endmodule

// ===== design/mqrf_ctrl.sv =====
// per-queue pointer state, record length store and request processing
module mqrf_ctrl #(
    parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
    parameter int SLOTS      = mqrf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = mqrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_acc,
    input  logic [mqrf_pkg::QSEL_W-1:0]    i_acc_q,
    input  logic                           i_proc,
    input  mqrf_pkg::t_req                 i_req,
    output mqrf_pkg::t_result              o_res,
    output mqrf_pkg::t_store_cmd           o_store_cmd,
    output logic [$clog2(NUM_QUEUES*SLOTS*SLOT_BYTES)-1:0] o_store_waddr,
    output logic [$clog2(NUM_QUEUES*SLOTS*SLOT_BYTES)-1:0] o_store_raddr,
    output logic [mqrf_pkg::BYTE_W-1:0]    o_store_wdata
);

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QXW    = (QW > mqrf_pkg::QSEL_W) ? QW : mqrf_pkg::QSEL_W;
    localparam int SW     = $clog2(SLOTS);
    localparam int OW     = $clog2(SLOT_BYTES + 1);
    localparam int BW     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int CW     = (OW > mqrf_pkg::LEN_W) ? OW : mqrf_pkg::LEN_W;
    localparam int LDEPTH = NUM_QUEUES * SLOTS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int AW     = $clog2(NUM_QUEUES * SLOTS * SLOT_BYTES);
    localparam int PCT_K  = mqrf_pkg::PCT_X_W + SW;
    localparam longint PCT_M = ((64'd1 << PCT_K) + SLOTS - 1) / SLOTS;
    localparam longint PCT_C = PCT_M * mqrf_pkg::PCT_SCALE;
    localparam int PW     = SW + $clog2(PCT_C) + 1;

    logic [SW-1:0] r_wslot [NUM_QUEUES];
    logic [SW-1:0] r_rslot [NUM_QUEUES];
    logic [OW-1:0] r_woff  [NUM_QUEUES];
    logic [OW-1:0] r_roff  [NUM_QUEUES];
    logic          r_drop  [NUM_QUEUES];
    logic [OW-1:0] r_len_mem [LDEPTH];
    logic [OW-1:0] r_len;

    logic [QXW-1:0] q_wide;
    logic           q_ok;
    logic [QW-1:0]  q_idx;
    logic [QXW-1:0] acc_q_wide;
    logic           acc_ok;
    logic [QW-1:0]  acc_idx;

    logic [SW-1:0]  cur_ws;
    logic [SW-1:0]  cur_rs;
    logic [OW-1:0]  cur_woff;
    logic [OW-1:0]  cur_roff;
    logic           cur_drop;
    logic [SW-1:0]  ws_inc;
    logic [SW-1:0]  rs_inc;

    logic [SW-1:0]  n_ws;
    logic [SW-1:0]  n_rs;
    logic [OW-1:0]  n_woff;
    logic [OW-1:0]  n_roff;
    logic           n_drop;

    logic                           start_drop;
    logic [OW-1:0]                  woff_new;
    logic [mqrf_pkg::STATUS_W-1:0]  st;
    logic                           rd_ok;
    logic                           rd_last;
    logic                           st_wen;
    logic                           len_wen;
    logic [OW-1:0]                  len_wdata;
    logic [LAW-1:0]                 len_waddr;
    logic [LAW-1:0]                 len_raddr;
    logic [SW-1:0]                  rs_pred;
    logic [BW-1:0]                  rd_off;

    logic [SW-1:0]  used;
    logic [PW-1:0]  pct_prod;

    assign q_wide     = QXW'(i_req.queue_sel);
    assign q_ok       = ({1'b0, q_wide} < (QXW+1)'(NUM_QUEUES));
    assign q_idx      = q_ok ? q_wide[QW-1:0] : '0;
    assign acc_q_wide = QXW'(i_acc_q);
    assign acc_ok     = ({1'b0, acc_q_wide} < (QXW+1)'(NUM_QUEUES));
    assign acc_idx    = acc_ok ? acc_q_wide[QW-1:0] : '0;

    assign cur_ws   = r_wslot[q_idx];
    assign cur_rs   = r_rslot[q_idx];
    assign cur_woff = r_woff[q_idx];
    assign cur_roff = r_roff[q_idx];
    assign cur_drop = r_drop[q_idx];
    assign ws_inc   = (cur_ws == SW'(SLOTS - 1)) ? '0 : cur_ws + 1'b1;
    assign rs_inc   = (cur_rs == SW'(SLOTS - 1)) ? '0 : cur_rs + 1'b1;

    assign rd_off = (cur_roff >= OW'(SLOT_BYTES)) ? BW'(SLOT_BYTES - 1) : cur_roff[BW-1:0];

    always_comb begin
        n_ws       = cur_ws;
        n_rs       = cur_rs;
        n_woff     = cur_woff;
        n_roff     = cur_roff;
        n_drop     = cur_drop;
        start_drop = 1'b0;
        woff_new   = cur_woff;
        st         = mqrf_pkg::ST_OK;
        rd_ok      = 1'b0;
        rd_last    = 1'b0;
        st_wen     = 1'b0;
        len_wen    = 1'b0;
        len_wdata  = cur_woff;
        unique case (i_req.req_type)
            mqrf_pkg::REQ_WRITE: begin
                start_drop = !cur_drop && (cur_woff == '0) && (ws_inc == cur_rs);
                if (cur_drop || start_drop) begin
                    st     = mqrf_pkg::ST_DROP;
                    n_drop = !i_req.wr_last;
                end else begin
                    if (cur_woff < OW'(SLOT_BYTES)) begin
                        st_wen   = 1'b1;
                        woff_new = cur_woff + 1'b1;
                    end else begin
                        st = mqrf_pkg::ST_TRUNC;
                    end
                    n_woff = woff_new;
                    if (i_req.wr_last) begin
                        len_wen   = 1'b1;
                        len_wdata = woff_new;
                        n_ws      = ws_inc;
                        n_woff    = '0;
                    end
                end
            end
            mqrf_pkg::REQ_READ: begin
                if (cur_rs == cur_ws) begin
                    st = mqrf_pkg::ST_EMPTY;
                end else if ((cur_roff == '0) && (CW'(r_len) > CW'(i_req.max_len))) begin
                    st = mqrf_pkg::ST_TOOLONG;
                end else begin
                    rd_ok = 1'b1;
                    if (((OW+1)'(cur_roff) + 1'b1) >= (OW+1)'(r_len)) begin
                        rd_last = 1'b1;
                        n_roff  = '0;
                        n_rs    = rs_inc;
                    end else begin
                        n_roff = cur_roff + 1'b1;
                    end
                end
            end
            mqrf_pkg::REQ_CLEAR: begin
                n_ws   = '0;
                n_rs   = '0;
                n_woff = '0;
                n_roff = '0;
                n_drop = 1'b0;
            end
            mqrf_pkg::REQ_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    // occupancy after the request
    assign used = (n_ws >= n_rs) ? SW'(n_ws - n_rs)
                : SW'((SW+1)'(n_ws) + (SW+1)'(SLOTS) - (SW+1)'(n_rs));
    assign pct_prod = PW'(used) * PW'(PCT_C);

    always_comb begin
        o_res = '0;
        if (!q_ok) begin
            o_res.status = mqrf_pkg::ST_EMPTY;
        end else begin
            o_res.status       = st;
            o_res.rd_ok        = rd_ok;
            o_res.rd_last      = rd_last;
            o_res.rec_len      = (i_req.req_type == mqrf_pkg::REQ_READ && cur_rs != cur_ws)
                               ? mqrf_pkg::LEN_W'(r_len) : '0;
            o_res.free_slots   = mqrf_pkg::FREE_W'((SW+1)'(SLOTS) - (SW+1)'(used));
            o_res.used_percent = mqrf_pkg::PCT_W'(pct_prod >> PCT_K);
            o_res.data_avail   = (used != '0);
        end
    end

    assign o_store_cmd.wr_en = i_proc && q_ok && st_wen;
    assign o_store_cmd.rd_en = i_proc && q_ok && rd_ok;
    assign o_store_wdata     = i_req.wr_byte;
    assign o_store_waddr = AW'((32'(q_idx) * 32'(SLOTS) + 32'(cur_ws)) * 32'(SLOT_BYTES)
                             + 32'(cur_woff[BW-1:0]));
    assign o_store_raddr = AW'((32'(q_idx) * 32'(SLOTS) + 32'(cur_rs)) * 32'(SLOT_BYTES)
                             + 32'(rd_off));

    // head length fetch for the incoming transaction, after this cycle's update
    assign rs_pred   = (i_proc && q_ok && (acc_idx == q_idx)) ? n_rs : r_rslot[acc_idx];
    assign len_waddr = LAW'(32'(q_idx) * 32'(SLOTS) + 32'(cur_ws));
    assign len_raddr = LAW'(32'(acc_idx) * 32'(SLOTS) + 32'(rs_pred));

    always_ff @(posedge i_clk) begin
        if (i_proc && q_ok && len_wen) begin
            r_len_mem[len_waddr] <= len_wdata;
        end
        if (i_acc) begin
            if (i_proc && q_ok && len_wen && (len_waddr == len_raddr)) begin
                r_len <= len_wdata;
            end else begin
                r_len <= r_len_mem[len_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_wslot[i] <= '0;
                r_rslot[i] <= '0;
                r_woff[i]  <= '0;
                r_roff[i]  <= '0;
                r_drop[i]  <= 1'b0;
            end
        end else if (i_proc && q_ok) begin
            r_wslot[q_idx] <= n_ws;
            r_rslot[q_idx] <= n_rs;
            r_woff[q_idx]  <= n_woff;
            r_roff[q_idx]  <= n_roff;
            r_drop[q_idx]  <= n_drop;
        end
    end

endmodule

// ===== design/multi_queue_record_fifo_unit.sv =====
// top level of the multi-queue record fifo
// pipeline: input request register, then result register
// throughput: one transaction per cycle while not stalled by i_ready, set by the
// pointer update and one byte store access per cycle
// reset: synchronous active-low reset clears pipeline valids and all queue pointers
module multi_queue_record_fifo_unit #(
    parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
    parameter int SLOTS      = mqrf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = mqrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mqrf_pkg::REQ_W-1:0]       i_req_type,
    input  logic [mqrf_pkg::QSEL_W-1:0]      i_queue_sel,
    input  logic [mqrf_pkg::BYTE_W-1:0]      i_wr_byte,
    input  logic                             i_wr_last,
    input  logic [mqrf_pkg::LEN_W-1:0]       i_max_len,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mqrf_pkg::STATUS_W-1:0]    o_status,
    output logic [mqrf_pkg::BYTE_W-1:0]      o_rd_byte,
    output logic                             o_rd_last,
    output logic [mqrf_pkg::LEN_W-1:0]       o_rec_len,
    output logic [mqrf_pkg::FREE_W-1:0]      o_free_slots,
    output logic [mqrf_pkg::PCT_W-1:0]       o_used_percent,
    output logic                             o_data_avail
);

    localparam int AW = $clog2(NUM_QUEUES * SLOTS * SLOT_BYTES);

    logic               r_in_valid;
    mqrf_pkg::t_req     r_in;
    mqrf_pkg::t_req     n_in;
    logic               r_out_valid;
    mqrf_pkg::t_result  r_res;
    mqrf_pkg::t_result  res;

    logic                         out_en;
    logic                         proc;
    logic                         acc;
    mqrf_pkg::t_store_cmd         store_cmd;
    logic [AW-1:0]                store_waddr;
    logic [AW-1:0]                store_raddr;
    logic [mqrf_pkg::BYTE_W-1:0]  store_wdata;
    logic [mqrf_pkg::BYTE_W-1:0]  store_byte;

    assign out_en  = !r_out_valid || i_ready;
    assign proc    = r_in_valid && out_en;
    assign o_ready = !r_in_valid || out_en;
    assign acc     = i_valid && o_ready;

    assign n_in.req_type  = i_req_type;
    assign n_in.queue_sel = i_queue_sel;
    assign n_in.wr_byte   = i_wr_byte;
    assign n_in.wr_last   = i_wr_last;
    assign n_in.max_len   = i_max_len;

    mqrf_ctrl #(
        .NUM_QUEUES (NUM_QUEUES),
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_acc_q       (i_queue_sel),
        .i_proc        (proc),
        .i_req         (r_in),
        .o_res         (res),
        .o_store_cmd   (store_cmd),
        .o_store_waddr (store_waddr),
        .o_store_raddr (store_raddr),
        .o_store_wdata (store_wdata)
    );

    mqrf_store #(
        .NUM_QUEUES (NUM_QUEUES),
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (store_cmd),
        .i_waddr   (store_waddr),
        .i_wdata   (store_wdata),
        .i_raddr   (store_raddr),
        .o_rd_byte (store_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in <= n_in;
        end
        if (proc) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_res.status;
    assign o_rd_byte      = r_res.rd_ok ? store_byte : '0;
    assign o_rd_last      = r_res.rd_last;
    assign o_rec_len      = r_res.rec_len;
    assign o_free_slots   = r_res.free_slots;
    assign o_used_percent = r_res.used_percent;
    assign o_data_avail   = r_res.data_avail;

endmodule

// ===== sim/tb_multi_queue_record_fifo_unit.sv =====
`timescale 1ns / 100ps
// testbench of the multi-queue record fifo: per-queue record predictor and scoreboard
module tb_multi_queue_record_fifo_unit;

    localparam int NQ    = mqrf_pkg::NUM_QUEUES_DEF;
    localparam int NSLOT = mqrf_pkg::SLOTS_DEF;
    localparam int SBYTE = mqrf_pkg::SLOT_BYTES_DEF;
    localparam int MAXLEN_TOP = (1 << mqrf_pkg::LEN_W) - 1;

    typedef struct packed {
        logic [mqrf_pkg::STATUS_W-1:0] status;
        logic [mqrf_pkg::BYTE_W-1:0]   rd_byte;
        logic                          rd_last;
        logic [mqrf_pkg::LEN_W-1:0]    rec_len;
        logic [mqrf_pkg::FREE_W-1:0]   free_slots;
        logic [mqrf_pkg::PCT_W-1:0]    used_percent;
        logic                          data_avail;
    } t_rec_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [mqrf_pkg::REQ_W-1:0]    i_req_type = '0;
    logic [mqrf_pkg::QSEL_W-1:0]   i_queue_sel = '0;
    logic [mqrf_pkg::BYTE_W-1:0]   i_wr_byte = '0;
    logic                          i_wr_last = 1'b0;
    logic [mqrf_pkg::LEN_W-1:0]    i_max_len = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [mqrf_pkg::STATUS_W-1:0] o_status;
    logic [mqrf_pkg::BYTE_W-1:0]   o_rd_byte;
    logic                          o_rd_last;
    logic [mqrf_pkg::LEN_W-1:0]    o_rec_len;
    logic [mqrf_pkg::FREE_W-1:0]   o_free_slots;
    logic [mqrf_pkg::PCT_W-1:0]    o_used_percent;
    logic                          o_data_avail;

    // per-queue record state of the predictor
    int          wr_slot_q [NQ];
    int          rd_slot_q [NQ];
    int          wr_off_q  [NQ];
    int          rd_off_q  [NQ];
    bit          drop_q    [NQ];
    logic [7:0]  rec_store [NQ][NSLOT][SBYTE];
    int          rec_size  [NQ][NSLOT];

    t_rec_result pending_results[$];
    t_rec_result expected_res;
    int          mismatches = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    multi_queue_record_fifo_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_queue_sel    (i_queue_sel),
        .i_wr_byte      (i_wr_byte),
        .i_wr_last      (i_wr_last),
        .i_max_len      (i_max_len),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_rd_byte      (o_rd_byte),
        .o_rd_last      (o_rd_last),
        .o_rec_len      (o_rec_len),
        .o_free_slots   (o_free_slots),
        .o_used_percent (o_used_percent),
        .o_data_avail   (o_data_avail)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_rec_result model_request(mqrf_pkg::t_req r);
        t_rec_result res;
        int q, used, len, off;
        res = '0;
        res.status = mqrf_pkg::ST_OK;
        q = int'(r.queue_sel);
        case (r.req_type)
            mqrf_pkg::REQ_WRITE: begin
                if (!drop_q[q] && wr_off_q[q] == 0 && (wr_slot_q[q] + 1) % NSLOT == rd_slot_q[q])
                    drop_q[q] = 1'b1;
                if (drop_q[q]) begin
                    res.status = mqrf_pkg::ST_DROP;
                    if (r.wr_last)
                        drop_q[q] = 1'b0;
                end else begin
                    if (wr_off_q[q] < SBYTE) begin
                        rec_store[q][wr_slot_q[q]][wr_off_q[q]] = r.wr_byte;
                        wr_off_q[q]++;
                    end else begin
                        res.status = mqrf_pkg::ST_TRUNC;
                    end
                    if (r.wr_last) begin
                        rec_size[q][wr_slot_q[q]] = wr_off_q[q];
                        wr_slot_q[q] = (wr_slot_q[q] + 1) % NSLOT;
                        wr_off_q[q] = 0;
                    end
                end
            end
            mqrf_pkg::REQ_READ: begin
                if (rd_slot_q[q] == wr_slot_q[q]) begin
                    res.status = mqrf_pkg::ST_EMPTY;
                end else begin
                    len = rec_size[q][rd_slot_q[q]];
                    res.rec_len = mqrf_pkg::LEN_W'(len);
                    if (rd_off_q[q] == 0 && len > int'(r.max_len)) begin
                        res.status = mqrf_pkg::ST_TOOLONG;
                    end else begin
                        off = (rd_off_q[q] >= SBYTE) ? SBYTE - 1 : rd_off_q[q];
                        res.rd_byte = rec_store[q][rd_slot_q[q]][off];
                        if (rd_off_q[q] + 1 >= len) begin
                            res.rd_last = 1'b1;
                            rd_off_q[q] = 0;
                            rd_slot_q[q] = (rd_slot_q[q] + 1) % NSLOT;
                        end else begin
                            rd_off_q[q]++;
                        end
                    end
                end
            end
            mqrf_pkg::REQ_CLEAR: begin
                wr_slot_q[q] = 0;
                rd_slot_q[q] = 0;
                wr_off_q[q] = 0;
                rd_off_q[q] = 0;
                drop_q[q] = 1'b0;
            end
            default: ;
        endcase
        used = (wr_slot_q[q] + NSLOT - rd_slot_q[q]) % NSLOT;
        res.free_slots = mqrf_pkg::FREE_W'(NSLOT - used);
        res.used_percent = mqrf_pkg::PCT_W'(used * mqrf_pkg::PCT_SCALE / NSLOT);
        res.data_avail = (used != 0);
        return res;
    endfunction

    function automatic mqrf_pkg::t_req make_req(logic [mqrf_pkg::REQ_W-1:0] kind, int q,
                                                int data, int last, int lim);
        mqrf_pkg::t_req r;
        r.req_type = kind;
        r.queue_sel = mqrf_pkg::QSEL_W'(q);
        r.wr_byte = mqrf_pkg::BYTE_W'(data);
        r.wr_last = (last != 0);
        r.max_len = mqrf_pkg::LEN_W'(lim);
        return r;
    endfunction

    task automatic send_req(mqrf_pkg::t_req r);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= r.req_type;
        i_queue_sel <= r.queue_sel;
        i_wr_byte   <= r.wr_byte;
        i_wr_last   <= r.wr_last;
        i_max_len   <= r.max_len;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(model_request(r));
    endtask

    task automatic write_record(int q, int len);
        for (int k = 0; k < len; k++)
            send_req(make_req(mqrf_pkg::REQ_WRITE, q, $urandom_range(255),
                              (k == len - 1) ? 1 : 0, $urandom_range(MAXLEN_TOP)));
    endtask

    task automatic read_bytes(int q, int n, int lim);
        for (int k = 0; k < n; k++)
            send_req(make_req(mqrf_pkg::REQ_READ, q, $urandom_range(255), $urandom_range(1),
                              lim));
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction expected none actual status %0d",
                         $time, o_status);
                mismatches++;
            end else begin
                expected_res = pending_results.pop_front();
                check_field("status", 16'(expected_res.status), 16'(o_status));
                check_field("rd_byte", 16'(expected_res.rd_byte), 16'(o_rd_byte));
                check_field("rd_last", 16'(expected_res.rd_last), 16'(o_rd_last));
                check_field("rec_len", 16'(expected_res.rec_len), 16'(o_rec_len));
                check_field("free_slots", 16'(expected_res.free_slots), 16'(o_free_slots));
                check_field("used_percent", 16'(expected_res.used_percent),
                            16'(o_used_percent));
                check_field("data_avail", 16'(expected_res.data_avail), 16'(o_data_avail));
            end
        end
    end

    task automatic test_directed();
        send_req(make_req(mqrf_pkg::REQ_QUERY, 0, 0, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 0, 'h00, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 0, 'hFF, 1, MAXLEN_TOP));
        send_req(make_req(mqrf_pkg::REQ_WRITE, NQ - 1, 'hA5, 1, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, 1));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, 2));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 0, 0, 0, MAXLEN_TOP));
        send_req(make_req(mqrf_pkg::REQ_READ, NQ - 1, 'hFF, 1, MAXLEN_TOP));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 3, 'h5A, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 3, 'hC3, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 3, 'h3C, 0, 0));
        // open record abandoned by the clear
        send_req(make_req(mqrf_pkg::REQ_CLEAR, 3, 0, 0, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 3, 0, 0, SBYTE));
        send_req(make_req(mqrf_pkg::REQ_QUERY, 3, 'hFF, 1, MAXLEN_TOP));
        send_req(make_req(mqrf_pkg::REQ_WRITE, 3, 'h81, 1, 0));
        send_req(make_req(mqrf_pkg::REQ_READ, 3, 0, 0, SBYTE));
        send_req(make_req(mqrf_pkg::REQ_CLEAR, NQ - 1, 'hFF, 1, MAXLEN_TOP));
    endtask

    task automatic test_full_drop();
        int q, total;
        int lens[NSLOT];
        q = $urandom_range(NQ - 1);
        total = 0;
        send_req(make_req(mqrf_pkg::REQ_CLEAR, q, 0, 0, 0));
        for (int s = 0; s < NSLOT - 1; s++) begin
            lens[s] = $urandom_range(2, 1);
            total += lens[s];
            write_record(q, lens[s]);
        end
        send_req(make_req(mqrf_pkg::REQ_QUERY, q, 0, 0, 0));
        write_record(q, 3);
        read_bytes(q, lens[0], lens[0]);
        total -= lens[0];
        write_record(q, 2);
        total += 2;
        write_record(q, 1);
        read_bytes(q, total + 1, SBYTE);
    endtask

    task automatic test_overlong();
        int q;
        q = $urandom_range(NQ - 1);
        send_req(make_req(mqrf_pkg::REQ_CLEAR, q, 0, 0, 0));
        write_record(q, SBYTE + 2);
        read_bytes(q, 1, SBYTE - 1);
        read_bytes(q, 1, SBYTE);
        // max_len no longer matters once the record is partly read
        for (int k = 0; k < 6; k++)
            read_bytes(q, 1, $urandom_range(MAXLEN_TOP));
        send_req(make_req(mqrf_pkg::REQ_CLEAR, q, 0, 0, 0));
    endtask

    task automatic test_random_mix(int n_ops);
        int pick, q, lim;
        for (int k = 0; k < n_ops; k++) begin
            pick = $urandom_range(99);
            q = ($urandom_range(4) == 0) ? $urandom_range(NQ - 1) : $urandom_range(3);
            lim = ($urandom_range(9) < 7) ? $urandom_range(MAXLEN_TOP, 8)
                                          : $urandom_range(MAXLEN_TOP);
            if (pick < 40)
                write_record(q, $urandom_range(6, 1));
            else if (pick < 70)
                read_bytes(q, $urandom_range(6, 1), lim);
            else if (pick < 75)
                send_req(make_req(mqrf_pkg::REQ_CLEAR, q, $urandom_range(255),
                                  $urandom_range(1), lim));
            else if (pick < 85)
                send_req(make_req(mqrf_pkg::REQ_QUERY, q, $urandom_range(255),
                                  $urandom_range(1), lim));
            else
                send_req(make_req(mqrf_pkg::REQ_W'($urandom_range(3)), $urandom_range(NQ - 1),
                                  $urandom_range(255), $urandom_range(1),
                                  $urandom_range(MAXLEN_TOP)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 25;
        rcv_idle = 47;
        test_directed();
        test_full_drop();
        test_random_mix(32);

        snd_idle = 47;
        rcv_idle = 25;
        test_full_drop();
        test_random_mix(32);

        snd_idle = 0;
        rcv_idle = 0;
        test_overlong();
        test_random_mix(32);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
